// ===== hdl/mwcrc_pkg.sv =====
// ----------------------------------------------------------------------------
// mwcrc_pkg: shared types, constants and the CRC byte step
// Kind codes, polynomials and the one-byte MSB-first update used by the core.
// ----------------------------------------------------------------------------
package mwcrc_pkg;

    localparam logic [1:0] KIND_CRC8  = 2'd0;
    localparam logic [1:0] KIND_CRC16 = 2'd1;
    localparam logic [1:0] KIND_CRC24 = 2'd2;
    localparam logic [1:0] KIND_CRC32 = 2'd3;

    localparam logic [31:0] POLY_CRC8  = 32'h0000_0007;
    localparam logic [31:0] POLY_CRC16 = 32'h0000_1021;
    localparam logic [31:0] POLY_CRC24 = 32'h0086_4CFB;
    localparam logic [31:0] POLY_CRC32 = 32'h04C1_1DB7;
    localparam logic [31:0] ALL_ONES   = 32'hFFFF_FFFF;

    // register map: byte address 4*i
    localparam int          ADDR_W       = 3;
    localparam logic        REG_CRC_KIND = 1'b0;

    typedef struct packed {
        logic        load;
        logic [31:0] crc;
    } t_result;

    function automatic logic [31:0] width_mask(input logic [1:0] kind);
        logic [31:0] m;
        case (kind)
            KIND_CRC8:  m = 32'h0000_00FF;
            KIND_CRC16: m = 32'h0000_FFFF;
            KIND_CRC24: m = 32'h00FF_FFFF;
            default:    m = 32'hFFFF_FFFF;
        endcase
        return m;
    endfunction

    function automatic logic [31:0] poly_of(input logic [1:0] kind);
        logic [31:0] p;
        case (kind)
            KIND_CRC8:  p = POLY_CRC8;
            KIND_CRC16: p = POLY_CRC16;
            KIND_CRC24: p = POLY_CRC24;
            default:    p = POLY_CRC32;
        endcase
        return p;
    endfunction

    // top bit of the selected width
    function automatic logic [31:0] top_bit(input logic [1:0] kind);
        logic [31:0] t;
        case (kind)
            KIND_CRC8:  t = 32'h0000_0080;
            KIND_CRC16: t = 32'h0000_8000;
            KIND_CRC24: t = 32'h0080_0000;
            default:    t = 32'h8000_0000;
        endcase
        return t;
    endfunction

    // byte aligned under the top of the selected width
    function automatic logic [31:0] align_byte(input logic [7:0] b, input logic [1:0] kind);
        logic [31:0] a;
        case (kind)
            KIND_CRC8:  a = {24'd0, b};
            KIND_CRC16: a = {16'd0, b, 8'd0};
            KIND_CRC24: a = {8'd0, b, 16'd0};
            default:    a = {b, 24'd0};
        endcase
        return a;
    endfunction

    // eight MSB-first shift steps; crc_in must already be masked
    function automatic logic [31:0] crc_byte(input logic [31:0] crc_in,
                                             input logic [7:0]  b,
                                             input logic [1:0]  kind);
        logic [31:0] c;
        logic [31:0] m;
        logic [31:0] p;
        logic [31:0] t;
        logic        top;
        m = width_mask(kind);
        p = poly_of(kind);
        t = top_bit(kind);
        c = crc_in ^ align_byte(b, kind);
        for (int i = 0; i < 8; i++) begin
            top = |(c & t);
            c   = (c << 1) & m;
            if (top) begin
                c = c ^ p;
            end
        end
        return c;
    endfunction

endpackage

// ===== hdl/mwcrc_apb.sv =====
// ----------------------------------------------------------------------------
// mwcrc_apb: configuration register file
// APB write/read of the CRC kind register; pready is tied high.
// ----------------------------------------------------------------------------
module mwcrc_apb (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [mwcrc_pkg::ADDR_W-1:0]  paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    output logic [1:0]                    o_kind
);

    logic [1:0] r_kind;
    logic       w_sel_kind;

    assign w_sel_kind = (paddr[2] == mwcrc_pkg::REG_CRC_KIND);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kind <= mwcrc_pkg::KIND_CRC8;
        end else if (psel && penable && pwrite && w_sel_kind) begin
            r_kind <= pwdata[1:0];
        end
    end

    assign prdata = w_sel_kind ? {30'd0, r_kind} : 32'd0;
    assign pready = 1'b1;
    assign o_kind = r_kind;

endmodule

// ===== hdl/mwcrc_core.sv =====
// ----------------------------------------------------------------------------
// mwcrc_core: input register and CRC update
// Holds one byte request, applies the byte step against the running CRC and
// hands the finished value to the output stage on the last byte.
// ----------------------------------------------------------------------------
module mwcrc_core (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic [1:0]           i_kind,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [7:0]           i_data,
    input  logic                 i_last,
    input  logic                 i_out_ready,
    output mwcrc_pkg::t_result   o_result
);

    logic        r_in_valid;
    logic [7:0]  r_in_data;
    logic        r_in_last;
    logic [31:0] r_running;
    logic        r_in_msg;

    logic        w_adv;
    logic [31:0] w_mask;
    logic [31:0] w_start;
    logic [31:0] w_crc;

    // a last byte waits only when the output register cannot take it
    assign w_adv   = r_in_valid && (!r_in_last || i_out_ready);
    assign o_ready = !r_in_valid || w_adv;

    assign w_mask  = mwcrc_pkg::width_mask(i_kind);
    assign w_start = r_in_msg ? (r_running & w_mask)
                   : ((i_kind == mwcrc_pkg::KIND_CRC32) ? mwcrc_pkg::ALL_ONES : 32'd0);
    assign w_crc   = mwcrc_pkg::crc_byte(w_start, r_in_data, i_kind);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in_data <= i_data;
            r_in_last <= i_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_running <= 32'd0;
            r_in_msg  <= 1'b0;
        end else if (w_adv) begin
            if (r_in_last) begin
                r_running <= 32'd0;
                r_in_msg  <= 1'b0;
            end else begin
                r_running <= w_crc;
                r_in_msg  <= 1'b1;
            end
        end
    end

    always_comb begin
        o_result.load = w_adv && r_in_last;
        o_result.crc  = ((i_kind == mwcrc_pkg::KIND_CRC32) ? ~w_crc : w_crc) & w_mask;
    end

endmodule

// ===== hdl/mwcrc_out.sv =====
// ----------------------------------------------------------------------------
// mwcrc_out: result register
// One-entry output register on the master stream; refills in the cycle the
// held result is taken.
// ----------------------------------------------------------------------------
module mwcrc_out (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  mwcrc_pkg::t_result   i_result,
    output logic                 o_can_load,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [31:0]          o_data
);

    logic        r_valid;
    logic [31:0] r_data;

    assign o_can_load = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_can_load) begin
            r_valid <= i_result.load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_result.load) begin
            r_data <= i_result.crc;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

// ===== hdl/multi_width_crc_engine.sv =====
// ----------------------------------------------------------------------------
// multi_width_crc_engine: MSB-first CRC-8/16/24/32 over a byte stream
// Top level: APB configuration, byte input stream, CRC result stream.
// ----------------------------------------------------------------------------
// Usage:
//   Message bytes enter on s_axis (tdata = byte, tlast = final byte of the
//   message). Each request is taken into an input register and applied to
//   the running CRC from there, so one byte per cycle is sustained while
//   no last byte waits for the output register. On the last byte the
//   finished CRC, masked to the selected width and zero-extended, is
//   loaded into the output register and offered on m_axis. Non-last
//   bytes produce no result.
//   The APB register at address 0 selects the CRC kind (0 CRC-8, 1 CRC-16,
//   2 CRC-24, 3 CRC-32 with init and final inversion); change it only while
//   no request is in flight.
//   Reset (synchronous, active low) clears the kind to CRC-8, empties both
//   registers and rearms for a new message.
//   If m_axis stalls with a result held, non-last bytes still flow; a last
//   byte waits in the input register and s_axis_tready drops until the
//   held result is taken.
// ----------------------------------------------------------------------------
module multi_width_crc_engine (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // APB configuration
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [mwcrc_pkg::ADDR_W-1:0]  paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    // byte input stream
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [7:0]                    s_axis_tdata,   // [7:0] data_byte
    input  logic                          s_axis_tlast,   // last_byte
    // CRC result stream
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [31:0]                   m_axis_tdata    // [31:0] crc_value
);

    logic [1:0]         w_kind;
    logic               w_out_ready;
    mwcrc_pkg::t_result w_result;

    mwcrc_apb u_apb (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_kind  (w_kind)
    );

    mwcrc_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_kind      (w_kind),
        .i_valid     (s_axis_tvalid),
        .o_ready     (s_axis_tready),
        .i_data      (s_axis_tdata),
        .i_last      (s_axis_tlast),
        .i_out_ready (w_out_ready),
        .o_result    (w_result)
    );

    mwcrc_out u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_result   (w_result),
        .o_can_load (w_out_ready),
        .o_valid    (m_axis_tvalid),
        .i_ready    (m_axis_tready),
        .o_data     (m_axis_tdata)
    );

`ifndef SYNTHESIS
    // input side only stalls behind a held, untaken result
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
        else $error("input stalled without output back-pressure");

    // a finished CRC is only handed over when the output register can hold it
    a_load_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_result.load |-> w_out_ready)
        else $error("result loaded into a full output register");

    // a loaded result shows up on the output stream next cycle
    a_load_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_result.load |=> m_axis_tvalid)
        else $error("loaded result not presented");

    // upper bits beyond the CRC-8 width stay clear on a CRC-8 result
    a_width: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_result.load && (w_kind == mwcrc_pkg::KIND_CRC8)) |->
        (w_result.crc[31:8] == 24'd0))
        else $error("CRC-8 result has bits above its width");
`endif

endmodule

// ===== tb/multi_width_crc_engine_tb.sv =====
// ----------------------------------------------------------------------------
// multi_width_crc_engine_tb: self-checking bench for the multi-width CRC engine
// Streams messages of random bytes through the engine under all four CRC
// kinds. A local bit-serial CRC predictor computes the expected CRC of each
// message. A checker compares every result in order. Both stream sides idle
// at random and also take a long receiver hold-off.
// ----------------------------------------------------------------------------
module multi_width_crc_engine_tb;

    localparam int CLK_HALF     = 5;
    localparam int RESET_CYCLES = 11;
    localparam int DRAIN_CYCLES = 8;
    localparam int STALL_LIMIT  = 5000;
    localparam int HOLD_CYCLES  = 300;
    localparam logic [mwcrc_pkg::ADDR_W-1:0] ADDR_KIND  =
        mwcrc_pkg::ADDR_W'(4 * mwcrc_pkg::REG_CRC_KIND);
    localparam logic [mwcrc_pkg::ADDR_W-1:0] ADDR_SPARE = mwcrc_pkg::ADDR_W'(4);

    logic                          i_clk         = 1'b0;
    logic                          i_rst_n       = 1'b0;
    logic                          psel          = 1'b0;
    logic                          penable       = 1'b0;
    logic                          pwrite        = 1'b0;
    logic [mwcrc_pkg::ADDR_W-1:0]  paddr         = '0;
    logic [31:0]                   pwdata        = '0;
    logic [31:0]                   prdata;
    logic                          pready;
    logic                          s_axis_tvalid = 1'b0;
    logic                          s_axis_tready;
    logic [7:0]                    s_axis_tdata  = '0;   // [7:0] data_byte
    logic                          s_axis_tlast  = 1'b0; // last_byte
    logic                          m_axis_tvalid;
    logic                          m_axis_tready = 1'b0;
    logic [31:0]                   m_axis_tdata;         // [31:0] crc_value

    // predictor state
    logic [1:0]           crc_kind_q    = mwcrc_pkg::KIND_CRC8;
    logic [31:0]          running_crc_q = '0;
    logic                 msg_open_q    = 1'b0;
    logic [31:0]          crc_expect_q[$];

    int                   errors        = 0;
    int                   send_idle_pct = 0;
    int                   recv_idle_pct = 0;
    int                   hold_request  = 0;
    int                   hold_left     = 0;
    int                   stall_count   = 0;

    multi_width_crc_engine u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        forever begin
            #CLK_HALF i_clk = ~i_clk;
        end
    end

    function automatic logic [31:0] crc_mask_for(input logic [1:0] kind);
        logic [63:0] m;
        m = (64'd1 << (8 * (kind + 1))) - 64'd1;
        return m[31:0];
    endfunction

    function automatic logic [31:0] crc_poly_for(input logic [1:0] kind);
        logic [31:0] p;
        case (kind)
            mwcrc_pkg::KIND_CRC8:  p = mwcrc_pkg::POLY_CRC8;
            mwcrc_pkg::KIND_CRC16: p = mwcrc_pkg::POLY_CRC16;
            mwcrc_pkg::KIND_CRC24: p = mwcrc_pkg::POLY_CRC24;
            default:               p = mwcrc_pkg::POLY_CRC32;
        endcase
        return p;
    endfunction

    // one byte shifted in MSB first, bit by bit
    function automatic logic [31:0] crc_shift_byte(input logic [31:0] crc_in,
                                                   input logic [7:0]  b,
                                                   input logic [1:0]  kind);
        int          n;
        logic [31:0] c;
        logic [31:0] m;
        logic        msb;
        n = 8 * (kind + 1);
        m = crc_mask_for(kind);
        c = crc_in ^ (32'(b) << (n - 8));
        for (int i = 0; i < 8; i++) begin
            msb = c[n-1];
            c   = (c << 1) & m;
            if (msb) begin
                c = c ^ crc_poly_for(kind);
            end
        end
        return c;
    endfunction

    task automatic predict_crc(input logic [7:0] b, input logic last);
        logic [31:0] c;
        logic [31:0] m;
        m = crc_mask_for(crc_kind_q);
        if (msg_open_q) begin
            c = running_crc_q & m;
        end else begin
            c = (crc_kind_q == mwcrc_pkg::KIND_CRC32) ? mwcrc_pkg::ALL_ONES : 32'd0;
        end
        c = crc_shift_byte(c, b, crc_kind_q);
        if (last) begin
            if (crc_kind_q == mwcrc_pkg::KIND_CRC32) begin
                c = c ^ mwcrc_pkg::ALL_ONES;
            end
            crc_expect_q.push_back(c & m);
            running_crc_q = '0;
            msg_open_q    = 1'b0;
        end else begin
            running_crc_q = c;
            msg_open_q    = 1'b1;
        end
    endtask

    // entered and left at a falling edge; tvalid stays high after a request
    task automatic send_byte(input logic [7:0] b, input logic last);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= 8'($urandom);
            s_axis_tlast  <= 1'($urandom);
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= last;
        do @(posedge i_clk); while (!s_axis_tready);
        predict_crc(b, last);
        @(negedge i_clk);
    endtask

    task automatic wait_idle;
        s_axis_tvalid <= 1'b0;
        @(negedge i_clk);
        while (crc_expect_q.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic apb_write(input logic [mwcrc_pkg::ADDR_W-1:0] addr,
                             input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (addr == ADDR_KIND) begin
            crc_kind_q = data[1:0];
        end
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic check_kind_readback;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= ADDR_KIND;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== {30'd0, crc_kind_q}) begin
            errors++;
            $display("%0t: kind readback mismatch expected %h actual %h",
                     $time, {30'd0, crc_kind_q}, prdata);
        end
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge i_clk);
    endtask

    // upper data bits are random; only the low two are kept
    task automatic set_kind(input logic [1:0] kind);
        wait_idle();
        apb_write(ADDR_KIND, {$urandom} & ~32'd3 | 32'(kind));
        check_kind_readback();
    endtask

    task automatic test_each_kind;
        for (int k = 0; k < 4; k++) begin
            set_kind(2'(k));
            send_byte(8'h00, 1'b1);
            send_byte(8'hFF, 1'b1);
            send_byte(8'h80, 1'b0);
            send_byte(8'h01, 1'b0);
            send_byte(8'hA5, 1'b1);
        end
    endtask

    task automatic test_register_bits;
        wait_idle();
        apb_write(ADDR_KIND, 32'hFFFF_FFFE);
        check_kind_readback();
        // no register behind this address
        apb_write(ADDR_SPARE, 32'hFFFF_FFFF);
        check_kind_readback();
        send_byte(8'h5A, 1'b1);
        wait_idle();
        apb_write(ADDR_SPARE, 32'h0000_0000);
        check_kind_readback();
        send_byte(8'hC3, 1'b1);
    endtask

    // running CRC is masked to the new width at the next byte
    task automatic test_kind_change_mid_message;
        set_kind(mwcrc_pkg::KIND_CRC32);
        send_byte(8'hDE, 1'b0);
        send_byte(8'hAD, 1'b0);
        set_kind(mwcrc_pkg::KIND_CRC8);
        send_byte(8'hBE, 1'b0);
        set_kind(mwcrc_pkg::KIND_CRC24);
        send_byte(8'hEF, 1'b1);
    endtask

    task automatic test_random_messages(input int tx_pct, input int rx_pct,
                                        input int n_bytes);
        int sent;
        int len;
        int pick;
        int split;
        send_idle_pct = tx_pct;
        recv_idle_pct = rx_pct;
        sent = 0;
        while (sent < n_bytes) begin
            if ($urandom_range(11) == 0) begin
                set_kind(2'($urandom_range(3)));
            end else if ($urandom_range(59) == 0) begin
                wait_idle();
                apb_write(ADDR_SPARE, $urandom);
            end
            pick = $urandom_range(99);
            if (pick < 80) begin
                len = $urandom_range(8, 1);
            end else if (pick < 95) begin
                len = $urandom_range(24, 9);
            end else begin
                len = $urandom_range(64, 25);
            end
            split = ($urandom_range(29) == 0) ? $urandom_range(len - 1, 0) : -1;
            for (int i = 0; i < len; i++) begin
                if (i == split && i != 0) begin
                    set_kind(2'($urandom_range(3)));
                end
                send_byte(8'($urandom), (i == len - 1));
            end
            sent += len;
        end
    endtask

    task automatic test_result_backpressure;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        set_kind(mwcrc_pkg::KIND_CRC16);
        hold_request = HOLD_CYCLES;
        for (int i = 0; i < 30; i++) begin
            send_byte(8'($urandom), ($urandom_range(2) != 0));
        end
        send_byte(8'($urandom), 1'b1);
    endtask

    // receiver side: random stalls plus a long hold-off on request
    initial begin
        forever begin
            @(negedge i_clk);
            if (hold_request > 0) begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (crc_expect_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected crc expected none actual %h",
                         $time, m_axis_tdata);
            end else if (m_axis_tdata !== crc_expect_q[0]) begin
                errors++;
                $display("%0t: crc mismatch expected %h actual %h",
                         $time, crc_expect_q[0], m_axis_tdata);
                void'(crc_expect_q.pop_front());
            end else begin
                void'(crc_expect_q.pop_front());
            end
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (psel && penable) || !i_rst_n) begin
            stall_count <= 0;
        end else if (stall_count >= STALL_LIMIT) begin
            $display("FAILURE");
            $finish;
        end else begin
            stall_count <= stall_count + 1;
        end
    end

    initial begin
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        send_idle_pct = 20;
        recv_idle_pct = 20;
        check_kind_readback();
        test_each_kind();
        test_register_bits();
        test_kind_change_mid_message();
        test_random_messages(35, 50, 600);
        test_random_messages(50, 35, 600);
        test_random_messages(0, 0, 600);
        test_result_backpressure();

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/mwcrc_pkg.sv
hdl/mwcrc_apb.sv
hdl/mwcrc_core.sv
hdl/mwcrc_out.sv
hdl/multi_width_crc_engine.sv
tb/multi_width_crc_engine_tb.sv
